// ===== hdl/osc_pkg.sv =====
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types, constants and helpers for the oversampled soft-clip saturator.
// ----------------------------------------------------------------------------
package osc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int OVERSAMPLE_RATIO = 8;
   localparam int NUM_FIXED_STAGES = 6;
   localparam int NUM_TAPS         = 5;
   localparam int STATE_DEPTH      = 28;
   localparam int ACC_W            = 46;

   localparam logic [3:0] LAST_IMG_STAGE = 4'd5;
   localparam logic [3:0] FIRST_DC_STAGE = 4'd6;
   localparam logic [3:0] FIRST_AA_STAGE = 4'd8;
   localparam logic [3:0] LAST_STAGE     = 4'd13;
   localparam logic [2:0] LAST_OS        = 3'(OVERSAMPLE_RATIO - 1);

   localparam logic [2:0] CSR_DRIVE      = 3'd0;
   localparam logic [2:0] CSR_DC_OFFSET  = 3'd1;
   localparam logic [2:0] CSR_DC_GAIN    = 3'd2;
   localparam logic [2:0] CSR_DC_FB1     = 3'd3;
   localparam logic [2:0] CSR_DC_FB2     = 3'd4;

   localparam logic [23:0]        DRIVE_RST   = 24'd65536;
   localparam logic signed [23:0] OFFSET_RST  = 24'sd0;
   localparam logic signed [31:0] DC_GAIN_RST = 32'sd1073694043;
   localparam logic signed [31:0] DC_FB1_RST  = 32'sd95610;
   localparam logic signed [31:0] DC_FB2_RST  = -32'sd1073646216;

   typedef logic signed [31:0] coef_type;

   // b0, b1, b2, a1, a2 per stage
   localparam coef_type FIXED_COEF [NUM_FIXED_STAGES][NUM_TAPS] = '{
      '{32'sd27991, 32'sd32072, 32'sd27991, -32'sd1416104405, 32'sd469399123},
      '{32'sd1073741824, -32'sd859268337, 32'sd1073741824, -32'sd1484995680,
        32'sd533194420},
      '{32'sd1073741824, -32'sd1525604596, 32'sd1073741824, -32'sd1597588248,
        32'sd638246099},
      '{32'sd1073741824, -32'sd1758144863, 32'sd1073741824, -32'sd1725374262,
        32'sd759287941},
      '{32'sd1073741824, -32'sd1853385762, 32'sd1073741824, -32'sd1852526769,
        32'sd882783283},
      '{32'sd1073741824, -32'sd1889774873, 32'sd1073741824, -32'sd1976876810,
        32'sd1008040636}
   };

   typedef enum logic [2:0] {
      ST_IDLE, ST_DRIVE, ST_BQ, ST_BQ_WB, ST_OFFSET, ST_DIV, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_B0, OP_B1, OP_A1, OP_B2, OP_A2
   } op_type;

   typedef struct packed {
      logic lo_en;
      logic load;
      logic hi_en;
      logic sub;
   } mac_ctl_type;

   function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
      if (v > 64'sd549755813887) begin
         return 40'sh7FFFFFFFFF;
      end else if (v < -64'sd549755813888) begin
         return 40'sh8000000000;
      end
      return v[39:0];
   endfunction

endpackage

// ===== hdl/osc_mac.sv =====
// ----------------------------------------------------------------------------
// osc_mac
// Shared rounded Q2.30 multiply with a 46-bit accumulator.
// ----------------------------------------------------------------------------
module osc_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  osc_pkg::mac_ctl_type            ctl,
   input  logic signed [39:0]              opnd,
   input  logic signed [32:0]              coef,
   input  logic signed [osc_pkg::ACC_W-1:0] load_val,
   output logic signed [osc_pkg::ACC_W-1:0] acc
);
   import osc_pkg::*;

   logic signed [49:0]      lo_ff;
   logic signed [23:0]      xh_ff;
   logic signed [32:0]      c_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [56:0]      hi;
   logic signed [49:0]      lo_rnd;
   logic signed [57:0]      q_sum;
   logic signed [ACC_W-1:0] q;

   assign hi     = xh_ff * c_ff;
   assign lo_rnd = lo_ff + 50'sd536870912;
   assign q_sum  = 58'(hi) + 58'(lo_rnd >>> 16);
   assign q      = ACC_W'(q_sum >>> 14);
   assign acc    = acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.lo_en) begin
         lo_ff <= $signed({1'b0, opnd[15:0]}) * coef;
         xh_ff <= opnd[39:16];
         c_ff  <= coef;
      end
      if (ctl.load) begin
         acc_ff <= load_val;
      end else if (ctl.hi_en) begin
         acc_ff <= ctl.sub ? acc_ff - q : acc_ff + q;
      end
   end

   a_no_load_and_add: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && ctl.hi_en))
      else $error("accumulator loaded and updated in one cycle");

endmodule

// ===== hdl/osc_div.sv =====
// ----------------------------------------------------------------------------
// osc_div
// Radix-2 restoring divider for the soft clip, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] mag,
   output logic        done,
   output logic [23:0] quot
);
   import osc_pkg::*;

   logic [40:0] den;
   logic [63:0] num;
   logic [40:0] den_ff;
   logic [40:0] rem_ff;
   logic [23:0] low_ff;
   logic [23:0] quot_ff;
   logic [4:0]  cnt_ff;
   logic        done_ff;
   logic [41:0] r2;
   logic        ge;

   assign den  = 41'(mag) + 41'd8388608;
   assign num  = {1'b0, mag, 23'b0} + 64'(den >> 1);
   assign r2   = {rem_ff, low_ff[23]};
   assign ge   = r2 >= {1'b0, den_ff};
   assign done = done_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= 5'd24;
         end else if (cnt_ff != 5'd0) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den;
         rem_ff  <= 41'(num[63:24]);
         low_ff  <= num[23:0];
      end else if (cnt_ff != 5'd0) begin
         rem_ff  <= ge ? 41'(r2 - {1'b0, den_ff}) : 41'(r2);
         low_ff  <= {low_ff[22:0], 1'b0};
         quot_ff <= {quot_ff[22:0], ge};
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> cnt_ff == 5'd0)
      else $error("divider restarted while busy");

endmodule

// ===== hdl/oversampled_soft_clip_saturator.sv =====
// ----------------------------------------------------------------------------
// oversampled_soft_clip_saturator
// Per request: a drive step, then per oversample 14 biquads, each of five
// products on the shared multiplier plus a write-back, and the offset add
// and the bit-serial soft-clip divider, for 8 oversamples, then an output
// step. One request at a time; the next is taken once the result sits in
// the output register. Synchronous reset clears filter state, control state
// and the CSRs; datapath registers are not reset.
// ----------------------------------------------------------------------------
module oversampled_soft_clip_saturator #(
   parameter int SAMPLE_WIDTH = osc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                           csr_write_en,
   input  logic [2:0]                     csr_index,
   input  logic [31:0]                    csr_wdata
);
   import osc_pkg::*;

   localparam int DPW = SAMPLE_WIDTH + 29;
   localparam logic signed [39:0] OUT_MAX = (40'sd1 <<< (SAMPLE_WIDTH - 1)) - 40'sd1;
   localparam logic signed [39:0] OUT_MIN = -(40'sd1 <<< (SAMPLE_WIDTH - 1));

   logic [23:0]        drive_ff;
   logic signed [23:0] offset_ff;
   logic signed [31:0] gain_ff;
   logic signed [31:0] fb1_ff;
   logic signed [31:0] fb2_ff;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [3:0] stg_ff, stg_in;
   logic [2:0] os_ff, os_in;
   logic       ph_ff, ph_in;
   logic       sign_ff, sign_in;
   logic signed [39:0] x_ff, x_in;
   logic signed [39:0] y_ff, y_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic signed [39:0] st_ff [STATE_DEPTH];
   logic [4:0]         st_raddr, st_waddr, base;
   logic               st_we;
   logic signed [39:0] st_wdata, st_rd;

   mac_ctl_type              mac_ctl;
   logic signed [39:0]       mac_opnd;
   logic signed [32:0]       mac_coef;
   logic signed [ACC_W-1:0]  mac_load;
   logic signed [ACC_W-1:0]  acc;
   logic signed [39:0]       acc_sat;

   logic        div_start, div_done;
   logic [39:0] div_mag;
   logic [23:0] div_quot;

   logic signed [SAMPLE_WIDTH+24:0] drv_prod;
   logic signed [DPW-1:0]           drv_rnd;
   logic signed [39:0]              clip_t;
   logic signed [39:0]              y_clamp;
   logic [2:0]  fidx;
   logic        is_dc;

   osc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .opnd     (mac_opnd),
      .coef     (mac_coef),
      .load_val (mac_load),
      .acc      (acc)
   );

   osc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (div_mag),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   assign base     = {stg_ff, 1'b0};
   assign st_rd    = st_ff[st_raddr];
   assign acc_sat  = sat40(64'(acc));
   assign drv_prod = $signed({1'b0, drive_ff}) * sample_ff;
   assign drv_rnd  = (DPW'(drv_prod) <<< 3) + DPW'(32'sd32768);
   assign clip_t   = sat40(64'(y_ff) + 64'(offset_ff));
   assign div_mag  = clip_t[39] ? 40'(-clip_t) : 40'(clip_t);
   assign y_clamp  = (y_ff > OUT_MAX) ? OUT_MAX : ((y_ff < OUT_MIN) ? OUT_MIN : y_ff);
   assign fidx     = (stg_ff >= FIRST_AA_STAGE) ? 3'(stg_ff - FIRST_AA_STAGE) : 3'(stg_ff);
   assign is_dc    = (stg_ff >= FIRST_DC_STAGE) && (stg_ff < FIRST_AA_STAGE);

   // coefficient for the current product
   always_comb begin
      mac_coef = '0;
      if (is_dc) begin
         case (op_ff)
            OP_B0:   mac_coef = 33'(gain_ff);
            OP_B1:   mac_coef = '0;
            OP_A1:   mac_coef = 33'(fb1_ff);
            OP_B2:   mac_coef = -33'(gain_ff);
            OP_A2:   mac_coef = 33'(fb2_ff);
            default: mac_coef = '0;
         endcase
      end else begin
         case (op_ff)
            OP_B0:   mac_coef = 33'(FIXED_COEF[fidx][0]);
            OP_B1:   mac_coef = 33'(FIXED_COEF[fidx][1]);
            OP_A1:   mac_coef = 33'(FIXED_COEF[fidx][3]);
            OP_B2:   mac_coef = 33'(FIXED_COEF[fidx][2]);
            OP_A2:   mac_coef = 33'(FIXED_COEF[fidx][4]);
            default: mac_coef = '0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      stg_in       = stg_ff;
      os_in        = os_ff;
      ph_in        = ph_ff;
      sign_in      = sign_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '0;
      mac_opnd     = x_ff;
      mac_load     = '0;
      st_raddr     = base;
      st_we        = 1'b0;
      st_waddr     = base;
      st_wdata     = acc_sat;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            x_in     = sat40(64'(drv_rnd >>> 16));
            stg_in   = '0;
            os_in    = '0;
            op_in    = OP_B0;
            ph_in    = 1'b0;
            state_in = ST_BQ;
         end
         ST_BQ: begin
            mac_ctl.lo_en = ~ph_ff;
            mac_ctl.hi_en = ph_ff;
            mac_ctl.sub   = (op_ff == OP_A1) || (op_ff == OP_A2);
            if ((op_ff == OP_A1) || (op_ff == OP_A2)) begin
               mac_opnd = y_ff;
            end
            if (!ph_ff) begin
               case (op_ff)
                  OP_B0: begin
                     mac_ctl.load = 1'b1;
                     mac_load     = ACC_W'(st_rd);
                  end
                  OP_B1: begin
                     y_in         = acc_sat;
                     st_raddr     = base + 5'd1;
                     mac_ctl.load = 1'b1;
                     mac_load     = ACC_W'(st_rd);
                  end
                  OP_B2: begin
                     st_we        = 1'b1;
                     mac_ctl.load = 1'b1;
                     mac_load     = '0;
                  end
                  default: begin
                  end
               endcase
            end
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (op_ff == OP_A2) begin
                  op_in    = OP_B0;
                  state_in = ST_BQ_WB;
               end else begin
                  op_in = op_type'(3'(op_ff + 3'd1));
               end
            end
         end
         ST_BQ_WB: begin
            st_we    = 1'b1;
            st_waddr = base + 5'd1;
            x_in     = y_ff;
            if (stg_ff == LAST_IMG_STAGE) begin
               state_in = ST_OFFSET;
            end else if (stg_ff == LAST_STAGE) begin
               if (os_ff == LAST_OS) begin
                  state_in = ST_OUT;
               end else begin
                  os_in    = os_ff + 3'd1;
                  stg_in   = '0;
                  x_in     = '0;
                  state_in = ST_BQ;
               end
            end else begin
               stg_in   = stg_ff + 4'd1;
               state_in = ST_BQ;
            end
         end
         ST_OFFSET: begin
            div_start = 1'b1;
            sign_in   = clip_t[39];
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               x_in     = sign_ff ? -40'(div_quot) : 40'(div_quot);
               stg_in   = FIRST_DC_STAGE;
               state_in = ST_BQ;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = SAMPLE_WIDTH'(y_clamp);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_B0;
         stg_ff       <= '0;
         os_ff        <= '0;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         stg_ff       <= stg_in;
         os_ff        <= os_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff     <= sign_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
      if (req_valid && req_ready) begin
         sample_ff <= req_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATE_DEPTH; i++) begin
            st_ff[i] <= '0;
         end
      end else if (st_we) begin
         st_ff[st_waddr] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff  <= DRIVE_RST;
         offset_ff <= OFFSET_RST;
         gain_ff   <= DC_GAIN_RST;
         fb1_ff    <= DC_FB1_RST;
         fb2_ff    <= DC_FB2_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DRIVE:     drive_ff  <= csr_wdata[23:0];
            CSR_DC_OFFSET: offset_ff <= csr_wdata[23:0];
            CSR_DC_GAIN:   gain_ff   <= csr_wdata;
            CSR_DC_FB1:    fb1_ff    <= csr_wdata;
            CSR_DC_FB2:    fb2_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DRIVE)
      else $error("accepted request did not start processing");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside output state");

   a_div_stage: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> stg_ff == LAST_IMG_STAGE)
      else $error("soft clip entered at wrong stage");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oversampled soft-clip saturator. A bit-exact
// predictor of the filter chain runs beside the block; each response is
// compared with the oldest predicted sample. Runs directed extremes, register
// sweeps, random bursts and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import osc_pkg::*;

   localparam int SW = 24;
   localparam longint S40_MAX = 64'sd549755813887;
   localparam longint S40_MIN = -64'sd549755813888;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [SW-1:0] req_sample_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_sample_out;
   logic                 csr_write_en = 1'b0;
   logic [2:0]           csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   int  errors = 0;
   bit  hold_off = 1'b0;
   bit  stall_free = 1'b0;
   logic signed [SW-1:0] expected_samples [$];

   logic [23:0]        drive_q;
   logic signed [23:0] offset_q;
   logic signed [31:0] gain_q, fb1_q, fb2_q;
   longint img_st [12];
   longint dcb_st [4];
   longint aa_st [12];

   oversampled_soft_clip_saturator u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   function automatic longint asr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clamp40(longint v);
      if (v > S40_MAX) return S40_MAX;
      if (v < S40_MIN) return S40_MIN;
      return v;
   endfunction

   function automatic longint round_mul(longint x, longint c);
      longint xh, xl, hi, lo;
      xh = asr(x, 16);
      xl = x - xh * 65536;
      hi = xh * c;
      lo = xl * c + (64'sd1 << 29);
      return asr(hi + asr(lo, 16), 14);
   endfunction

   function automatic longint run_biquad(inout longint s0, inout longint s1,
                                         input longint k [5], input longint x);
      longint y;
      y = clamp40(s0 + round_mul(x, k[0]));
      s0 = clamp40(s1 + round_mul(x, k[1]) - round_mul(y, k[3]));
      s1 = clamp40(round_mul(x, k[2]) - round_mul(y, k[4]));
      return y;
   endfunction

   function automatic longint clip_curve(longint t);
      longint mag, den, q;
      mag = (t < 0) ? -t : t;
      den = (64'sd1 << 23) + mag;
      q = ((mag << 23) + den / 2) / den;
      return (t < 0) ? -q : q;
   endfunction

   function automatic void reset_predictor();
      drive_q = DRIVE_RST;
      offset_q = OFFSET_RST;
      gain_q = DC_GAIN_RST;
      fb1_q = DC_FB1_RST;
      fb2_q = DC_FB2_RST;
      foreach (img_st[i]) begin
         img_st[i] = 0;
         aa_st[i] = 0;
      end
      foreach (dcb_st[i]) dcb_st[i] = 0;
   endfunction

   function automatic logic signed [SW-1:0] saturate_sample(logic signed [SW-1:0] x);
      longint prod, v, y, k [5], dck [5];
      prod = longint'(drive_q) * longint'(x) * OVERSAMPLE_RATIO;
      dck[0] = gain_q;
      dck[1] = 0;
      dck[2] = -longint'(gain_q);
      dck[3] = fb1_q;
      dck[4] = fb2_q;
      y = 0;
      for (int i = 0; i < OVERSAMPLE_RATIO; i++) begin
         v = (i == 0) ? clamp40(asr(prod + (64'sd1 << 15), 16)) : 0;
         for (int j = 0; j < NUM_FIXED_STAGES; j++) begin
            for (int t = 0; t < 5; t++) k[t] = FIXED_COEF[j][t];
            v = run_biquad(img_st[2*j], img_st[2*j+1], k, v);
         end
         v = clip_curve(clamp40(v + longint'(offset_q)));
         v = run_biquad(dcb_st[0], dcb_st[1], dck, v);
         v = run_biquad(dcb_st[2], dcb_st[3], dck, v);
         for (int j = 0; j < NUM_FIXED_STAGES; j++) begin
            for (int t = 0; t < 5; t++) k[t] = FIXED_COEF[j][t];
            v = run_biquad(aa_st[2*j], aa_st[2*j+1], k, v);
         end
         y = v;
      end
      if (y > 64'sd8388607) y = 64'sd8388607;
      if (y < -64'sd8388608) y = -64'sd8388608;
      return y[SW-1:0];
   endfunction

   task automatic wait_drained();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (1600) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DRIVE:     drive_q = value[23:0];
         CSR_DC_OFFSET: offset_q = value[23:0];
         CSR_DC_GAIN:   gain_q = value;
         CSR_DC_FB1:    fb1_q = value;
         CSR_DC_FB2:    fb2_q = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send_request(logic signed [SW-1:0] x);
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(saturate_sample(x));
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random(int n, bit wide);
      logic signed [SW-1:0] x;
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            repeat ($urandom_range(0, 30)) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         burst--;
         x = SW'($urandom);
         if (!wide && $urandom_range(0, 3) != 0) x = x >>> $urandom_range(1, 16);
         send_request(x);
      end
   endtask

   task automatic test_directed_extremes();
      logic signed [SW-1:0] vals [10];
      vals = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000001, 24'shFFFFFF,
               24'sh555555, 24'shAAAAAA, 24'sh400000, 24'shC00000, 24'sh7FFFFF};
      foreach (vals[i]) send_request(vals[i]);
      wait_drained();
   endtask

   task automatic test_large_drive();
      write_reg(CSR_DRIVE, 32'hFFFFFF);
      send_request(24'sh7FFFFF);
      send_request(24'sh800000);
      send_request(24'sh7FFFFF);
      send_random(5, 1'b1);
      wait_drained();
      write_reg(CSR_DRIVE, 32'h000000);
      send_request(24'sh7FFFFF);
      send_request(24'sh123456);
      wait_drained();
   endtask

   task automatic test_offset_and_dc_coeffs();
      write_reg(CSR_DRIVE, 32'hFF010000);
      write_reg(CSR_DC_OFFSET, 32'h007FFFFF);
      send_random(4, 1'b1);
      wait_drained();
      write_reg(CSR_DC_OFFSET, 32'hAB800000);
      write_reg(CSR_DC_GAIN, 32'h7FFFFFFF);
      write_reg(CSR_DC_FB1, 32'h80000000);
      write_reg(CSR_DC_FB2, 32'h7FFFFFFF);
      send_random(4, 1'b1);
      wait_drained();
      write_reg(CSR_DC_GAIN, 32'h80000000);
      write_reg(CSR_DC_FB1, 32'h7FFFFFFF);
      write_reg(CSR_DC_FB2, 32'h80000000);
      write_reg(3'd7, 32'hFFFFFFFF);
      write_reg(3'd5, 32'h12345678);
      send_random(4, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_DRIVE, (p == 3) ? 32'h00010000 : $urandom_range(0, 32'h80000));
         write_reg(CSR_DC_OFFSET, $urandom_range(0, 32'h3FFFF) - 32'h1FFFF);
         write_reg(CSR_DC_GAIN, (p == 3) ? 32'(DC_GAIN_RST) : $urandom);
         write_reg(CSR_DC_FB1, (p == 3) ? 32'(DC_FB1_RST) : $urandom);
         write_reg(CSR_DC_FB2, (p == 3) ? 32'(DC_FB2_RST) : $urandom);
         send_random(130, p == 0);
         wait_drained();
      end
   endtask

   task automatic test_output_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (6000) @(posedge clock);
            hold_off = 1'b0;
         end
         send_random(8, 1'b0);
      join
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else if (stall_free) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t unexpected response: expected none, actual %0d", $time,
                     rsp_sample_out);
            errors++;
         end else begin
            if (rsp_sample_out !== expected_samples[0]) begin
               $display("%0t sample_out mismatch: expected %0d, actual %0d", $time,
                        expected_samples[0], rsp_sample_out);
               errors++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   initial begin
      reset_predictor();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_extremes();
      test_large_drive();
      test_offset_and_dc_coeffs();
      test_output_backpressure();
      stall_free = 1'b1;
      send_random(20, 1'b0);
      wait_drained();
      stall_free = 1'b0;
      test_random_settings();
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/osc_pkg.sv
hdl/osc_mac.sv
hdl/osc_div.sv
hdl/oversampled_soft_clip_saturator.sv
tb/tb.sv
